FILE: design/col_pkg.sv
`default_nettype none
package col_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int HANDLE_W = 16;
    localparam int ID_W     = 16;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        CMD_APPEND    = 2'd0,
        CMD_REMOVE_AT = 2'd1,
        CMD_REMOVE_ID = 2'd2,
        CMD_NOP       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE         = 2'd0,
        ST_FULL         = 2'd1,
        ST_BAD_POSITION = 2'd2,
        ST_NOT_FOUND    = 2'd3
    } t_status;

    // Broadcast from the top level to every cell in the chain.
    typedef struct packed {
        logic                fire;
        t_cmd                cmd;
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
        logic [POS_W-1:0]    position;
        logic [CNT_W-1:0]    count;
    } t_cell_cmd;

endpackage
`default_nettype wire

FILE: design/col_cell.sv
`default_nettype none
module col_cell (
    input  wire logic                       i_clk,
    input  wire logic [col_pkg::CNT_W-1:0]  i_index,
    input  wire col_pkg::t_cell_cmd         i_cmd,
    input  wire logic                       i_hit_below,
    output logic                            o_hit_below,
    input  wire logic [col_pkg::HANDLE_W-1:0] i_up_handle,
    input  wire logic [col_pkg::ID_W-1:0]   i_up_id,
    output logic [col_pkg::HANDLE_W-1:0]    o_handle,
    output logic [col_pkg::ID_W-1:0]        o_id
);
    import col_pkg::*;

    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [ID_W-1:0]     r_id, n_id;
    logic                occupied;
    logic                hit;
    logic                shift;
    logic [CNT_W+POS_W-1:0] pos_x;
    logic [CNT_W+POS_W-1:0] idx_x;

    assign pos_x    = {{CNT_W{1'b0}}, i_cmd.position};
    assign idx_x    = {{POS_W{1'b0}}, i_index};
    assign occupied = i_index < i_cmd.count;

    always_comb begin
        unique case (i_cmd.cmd)
            CMD_REMOVE_AT: hit = occupied && (pos_x == idx_x);
            CMD_REMOVE_ID: hit = occupied && (r_id == i_cmd.id);
            CMD_APPEND,
            CMD_NOP:       hit = 1'b0;
        endcase
    end

    // Once a hit is seen at or below this cell, every occupied cell above it pulls down.
    assign o_hit_below = i_hit_below | hit;
    assign shift       = occupied & o_hit_below;

    always_comb begin
        n_handle = r_handle;
        n_id     = r_id;
        if (i_cmd.fire) begin
            if (i_cmd.cmd == CMD_APPEND && i_index == i_cmd.count) begin
                n_handle = i_cmd.handle;
                n_id     = i_cmd.id;
            end else if (shift) begin
                n_handle = i_up_handle;
                n_id     = i_up_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_handle <= n_handle;
        r_id     <= n_id;
    end

    assign o_handle = r_handle;
    assign o_id     = r_id;

endmodule
`default_nettype wire

FILE: design/compacting_ordered_list.sv
`default_nettype none
// Ordered list of up to CAPACITY entries (handle, id) with compacting removal.
// Slave channel: one command word per handshake; tuser carries the command
// (append, remove at position, remove first matching id), tdata the operands.
// Master channel: one result word per command carrying status and the entry
// count after the command.
// Each entry lives in one cell of a chain. A removal raises a hit in the cell
// being dropped; the hit ripples up the chain and every occupied cell above it
// takes its upper neighbor's contents in the same cycle, so the list is
// compacted in one step.
// The result is registered and appears in the cycle after the command is accepted.
// Throughput: one command per cycle while the receiver takes each result, set by
// the cell update and the one-deep output register.
// Reset empties the list and drops any pending result. While the receiver
// stalls, the held result stays on the master port and the slave side accepts
// no new command until that result is taken.
module compacting_ordered_list (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    // [15:0] item_handle, [31:16] item_id, [35:32] position, [39:36] zero
    input  wire logic [39:0] i_s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0] i_s_axis_tuser,
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    // [1:0] status, [6:2] entry_count, [7] zero
    output logic [7:0]      o_m_axis_tdata
);
    import col_pkg::*;

    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    logic [CNT_W-1:0] r_count, n_count;

    t_cell_cmd        cell_cmd;
    logic             accept;
    logic             found;
    logic [CNT_W+COUNT_W-1:0] count_x;

    logic [CAPACITY:0]  hit_chain;
    logic [HANDLE_W-1:0] handle_chain [CAPACITY+1];
    logic [ID_W-1:0]     id_chain     [CAPACITY+1];

    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    assign cell_cmd.fire     = accept;
    assign cell_cmd.cmd      = t_cmd'(i_s_axis_tuser);
    assign cell_cmd.handle   = i_s_axis_tdata[15:0];
    assign cell_cmd.id       = i_s_axis_tdata[31:16];
    assign cell_cmd.position = i_s_axis_tdata[35:32];
    assign cell_cmd.count    = r_count;

    assign hit_chain[0]           = 1'b0;
    assign handle_chain[CAPACITY] = '0;
    assign id_chain[CAPACITY]     = '0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        col_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (CNT_W'(k)),
            .i_cmd       (cell_cmd),
            .i_hit_below (hit_chain[k]),
            .o_hit_below (hit_chain[k+1]),
            .i_up_handle (handle_chain[k+1]),
            .i_up_id     (id_chain[k+1]),
            .o_handle    (handle_chain[k]),
            .o_id        (id_chain[k])
        );
    end

    assign found = hit_chain[CAPACITY];

    always_comb begin
        n_out_valid = r_out_valid & ~i_m_axis_tready;
        n_status    = r_status;
        n_count     = r_count;
        if (accept) begin
            n_out_valid = 1'b1;
            n_status    = ST_DONE;
            unique case (cell_cmd.cmd)
                CMD_APPEND: begin
                    if (r_count >= CNT_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_REMOVE_AT: begin
                    if (found) begin
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        n_status = ST_BAD_POSITION;
                    end
                end
                CMD_REMOVE_ID: begin
                    if (found) begin
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                CMD_NOP: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_status    <= ST_DONE;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_status    <= n_status;
        end
    end

    assign count_x         = {{COUNT_W{1'b0}}, r_count};
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, count_x[COUNT_W-1:0], r_status};

endmodule
`default_nettype wire
